@@ rtl/core/csv_separator_detector_macros.svh @@
// Assertion macros for the separator detector.
// Define ASSERT_OFF to compile the checks out.
`ifndef CSV_SEPARATOR_DETECTOR_MACROS_SVH
`define CSV_SEPARATOR_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge outside reset
`define CSVSEP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("csv separator detector check failed");

// cons must hold in the cycle after ante
`define CSVSEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv separator detector check failed");

`else

`define CSVSEP_ASSERT_ALWAYS(label, cond)
`define CSVSEP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/csvsep_pkg.sv @@
package csvsep_pkg;

  localparam int NUM_CAND        = 4;
  localparam int CAND_IDX_W      = 2;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_INDEX_W     = 8;

  typedef logic [7:0] byte_t;

  localparam byte_t LINE_END   = 8'd10;
  localparam byte_t QUOTE_BYTE = 8'd34;

  // comma, period, space, semicolon
  localparam byte_t CAND_RESET [NUM_CAND] = '{8'd44, 8'd46, 8'd32, 8'd59};

  typedef enum logic [1:0] {
    QM_OUT  = 2'd0,
    QM_IN   = 2'd1,
    QM_SEEN = 2'd2,
    QM_FAIL = 2'd3
  } qmode_t;

endpackage

@@ rtl/core/csv_separator_detector.sv @@
// Separator detector: streams a text file in one byte per transaction (byte 10
// ends a line, end_of_file marks the last byte) and reports which of four
// programmable candidate characters splits every line into the same number of
// unquoted separators, nonzero on each line after the first. Bytes are taken at
// one per cycle; the four quote machines and saturating COUNT_WIDTH-bit counters
// update in the cycle a byte is accepted, and the single result appears in the
// output register in the cycle after the last byte. A last byte is held off only
// while the previous result still sits unread in that register. After each
// report the line and candidate state returns to its reset value; the candidate
// characters keep their programmed values. Write candidate characters only while idle.
module csv_separator_detector
  import csvsep_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // byte stream
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_file,
  // result
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [CAND_IDX_W-1:0]  separator_index,
  output logic [7:0]             separator_char,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

`include "csv_separator_detector_macros.svh"

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  byte_t                  cand_char [NUM_CAND];
  qmode_t                 qmode [NUM_CAND];
  qmode_t                 qmode_next [NUM_CAND];
  logic [COUNT_WIDTH-1:0] count [NUM_CAND];
  logic [COUNT_WIDTH-1:0] count_next [NUM_CAND];
  logic [COUNT_WIDTH-1:0] first_count [NUM_CAND];
  logic [COUNT_WIDTH-1:0] first_count_next [NUM_CAND];
  logic [NUM_CAND-1:0]    alive;
  logic [NUM_CAND-1:0]    alive_next;
  logic                   on_first_line;
  logic                   on_first_line_next;
  logic                   line_has_bytes;
  logic                   line_has_bytes_next;

  logic                   in_acc;
  logic                   is_lf;
  logic                   line_done;
  logic                   res_found;
  logic [CAND_IDX_W-1:0]  res_index;
  byte_t                  res_char;

  assign is_lf     = (text_byte == LINE_END);
  assign line_done = is_lf || end_of_file;
  // only a last byte needs room in the output register
  assign in_stall  = out_valid && out_stall && end_of_file;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    qmode_t                 m;
    logic [COUNT_WIDTH-1:0] c;
    logic [COUNT_WIDTH-1:0] lc;
    logic                   is_q;
    logic                   is_s;

    for (int k = 0; k < NUM_CAND; k++) begin
      m    = qmode[k];
      c    = count[k];
      is_q = (text_byte == QUOTE_BYTE);
      is_s = (text_byte == cand_char[k]);
      if (!is_lf) begin
        case (qmode[k])
          QM_OUT: begin
            if (is_q) begin
              m = QM_IN;
            end else if (is_s && c != COUNT_MAX) begin
              c = c + COUNT_WIDTH'(1);
            end
          end
          QM_IN: begin
            if (is_q) begin
              m = QM_SEEN;
            end
          end
          QM_SEEN: begin
            if (is_q) begin
              m = QM_IN;
            end else if (is_s) begin
              m = QM_OUT;
              if (c != COUNT_MAX) begin
                c = c + COUNT_WIDTH'(1);
              end
            end else begin
              m = QM_FAIL;
            end
          end
          default: m = QM_FAIL;
        endcase
      end

      // open or broken quote at line end zeroes the line
      lc = (m == QM_IN || m == QM_FAIL) ? '0 : c;

      qmode_next[k]       = m;
      count_next[k]       = c;
      first_count_next[k] = first_count[k];
      alive_next[k]       = alive[k];
      if (line_done) begin
        if (on_first_line) begin
          first_count_next[k] = lc;
        end else if (alive[k] && (lc != first_count[k] || lc == '0)) begin
          alive_next[k] = 1'b0;
        end
        qmode_next[k] = QM_OUT;
        count_next[k] = '0;
      end
    end

    on_first_line_next  = line_done ? 1'b0 : on_first_line;
    line_has_bytes_next = line_done ? 1'b0 : (line_has_bytes || !is_lf);

    // lowest surviving index wins
    res_found = 1'b0;
    res_index = '0;
    res_char  = '0;
    for (int k = NUM_CAND - 1; k >= 0; k--) begin
      if (alive_next[k]) begin
        res_found = 1'b1;
        res_index = CAND_IDX_W'(k);
        res_char  = cand_char[k];
      end
    end

    if (end_of_file) begin
      for (int k = 0; k < NUM_CAND; k++) begin
        qmode_next[k]       = QM_OUT;
        count_next[k]       = '0;
        first_count_next[k] = '0;
      end
      alive_next          = '1;
      on_first_line_next  = 1'b1;
      line_has_bytes_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CAND; k++) begin
        cand_char[k]   <= CAND_RESET[k];
        qmode[k]       <= QM_OUT;
        count[k]       <= '0;
        first_count[k] <= '0;
      end
      alive          <= '1;
      on_first_line  <= 1'b1;
      line_has_bytes <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < CFG_INDEX_W'(NUM_CAND)) begin
        cand_char[cfg_index[CAND_IDX_W-1:0]] <= cfg_data;
      end
      if (in_acc) begin
        qmode          <= qmode_next;
        count          <= count_next;
        first_count    <= first_count_next;
        alive          <= alive_next;
        on_first_line  <= on_first_line_next;
        line_has_bytes <= line_has_bytes_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && end_of_file) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // load the result with the last byte of the file
  always_ff @(posedge clk) begin
    if (in_acc && end_of_file) begin
      found           <= res_found;
      separator_index <= res_index;
      separator_char  <= res_char;
    end
  end

  `CSVSEP_ASSERT_ALWAYS(a_stall_needs_result, !in_stall || out_valid)
  `CSVSEP_ASSERT_NEXT(a_eof_clears, in_acc && end_of_file,
                      out_valid && on_first_line && (&alive) && !line_has_bytes)
  `CSVSEP_ASSERT_ALWAYS(a_none_is_zero,
                        !out_valid || found || (separator_index == '0 && separator_char == '0))
  `CSVSEP_ASSERT_NEXT(a_line_end_clears, in_acc && text_byte == LINE_END, !line_has_bytes)

endmodule
